// ===== sv/calts_pkg.sv =====
`default_nettype none

package calts_pkg;

   // Default sizes, handed to the top level parameters.
   localparam int FIELD_CHARS_DEFAULT = 9;
   localparam int MAX_LINE_DEFAULT    = 64;
   localparam int MID_DEPTH_DEFAULT   = 2;
   localparam int OUT_DEPTH_DEFAULT   = 4;

   // Characters that steer the parser.
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // A CR LF closes a line only when the line is longer than this.
   localparam int CLOSE_MIN = 5;

   // Field accumulator: magnitude in thousandths, saturating.
   localparam int ACC_W        = 31;
   localparam int SUM_W        = ACC_W + 5;
   localparam int DIGIT_WEIGHT = 1000;
   localparam int FRAC_MAX     = 3;
   localparam logic [ACC_W-1:0] MAG_LIMIT = {ACC_W{1'b1}};

   // Speed scaling: one speed step per nine degrees.
   localparam int ANGLE_W    = 32;
   localparam int DIFF_W     = ANGLE_W + 1;
   localparam int SPEED_W    = 7;
   localparam int SPEED_DIV  = 9 * DIGIT_WEIGHT;
   localparam int SPEED_MAX  = 63;
   localparam int SPEED_MIN  = -64;
   localparam int SAT_HI     = SPEED_MAX * SPEED_DIV;
   localparam int SAT_LO     = -SPEED_MIN * SPEED_DIV;
   localparam int DIV_STEPS  = 6;
   localparam int MAG_W      = 20;

   // DAC code mapping.
   localparam int DAC_W    = 12;
   localparam int DAC_MID  = 2048;
   localparam int DAC_STEP = 204;
   localparam int DAC_MAX  = 4095;
   localparam int SCALE_W  = 17;

   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [SPEED_W-1:0] speed_type;
   typedef logic [DAC_W-1:0]          dac_type;

   // One closed line: the three angles after the last field is committed.
   typedef struct packed {
      angle_type yaw;
      angle_type pitch;
      angle_type roll;
   } line_event_type;

   typedef struct packed {
      speed_type run_speed;
      speed_type right_speed;
      dac_type   run_dac_code;
      dac_type   right_dac_code;
   } result_type;

   // Weight of a fraction digit by its place after the point.
   function automatic logic [6:0] frac_scale(input logic [1:0] place);
      logic [6:0] weight;
      case (place)
         2'd0:    weight = 7'd100;
         2'd1:    weight = 7'd10;
         default: weight = 7'd1;
      endcase
      return weight;
   endfunction

endpackage

`default_nettype wire

// ===== sv/calts_fifo.sv =====
`default_nettype none

module calts_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [WIDTH-1:0]             push_data,
   input  wire logic                         pop,
   output logic [WIDTH-1:0]                  pop_data,
   output logic                              full,
   output logic                              empty,
   output logic [$clog2(DEPTH+1)-1:0]        count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and occupancy updates, with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; only written entries are ever read.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/calts_front.sv =====
`default_nettype none

module calts_front #(
   parameter int FIELD_CHARS = calts_pkg::FIELD_CHARS_DEFAULT,
   parameter int MAX_LINE    = calts_pkg::MAX_LINE_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic                      csr_stream_enable,
   input  wire logic                      byte_accept,
   input  wire logic [7:0]                rx_byte,
   output logic                           event_push,
   output calts_pkg::line_event_type      event_data
);

   localparam int LW = $clog2(MAX_LINE + 1);
   localparam int CW = $clog2(FIELD_CHARS + 1);
   localparam int ACC_W = calts_pkg::ACC_W;
   localparam int SUM_W = calts_pkg::SUM_W;
   localparam int ANGLE_MSB = calts_pkg::ANGLE_W - 1;

   logic                       stream_en_ff;
   logic [LW-1:0]              line_len_ff, line_len_in;
   logic                       last_cr_ff, last_cr_in;
   logic [1:0]                 field_num_ff, field_num_in;
   logic [CW-1:0]              field_chars_ff, field_chars_in;
   logic                       sign_ff, sign_in;
   logic                       point_ff, point_in;
   logic                       stop_ff, stop_in;
   logic [1:0]                 frac_ff, frac_in;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   calts_pkg::angle_type       parsed_ff [3];
   calts_pkg::angle_type       parsed_in [3];
   calts_pkg::angle_type       parsed_next [3];

   logic                       is_close;
   logic                       is_comma;
   logic                       is_digit;
   logic                       is_sign_char;
   logic                       frac_room;
   logic [3:0]                 digit;
   logic [ANGLE_MSB:0]         commit_mag;
   calts_pkg::angle_type       commit_value;
   logic [SUM_W-1:0]           times_ten;
   logic [13:0]                digit_thou;
   logic [10:0]                frac_add;
   logic [SUM_W-1:0]           digit_sum;
   logic [ACC_W-1:0]           digit_acc;

   // Character classes of the incoming beat.
   assign is_close = (line_len_ff > LW'(calts_pkg::CLOSE_MIN)) && last_cr_ff &&
                     (rx_byte == calts_pkg::CHAR_LF);
   assign is_comma = (rx_byte == calts_pkg::CHAR_COMMA);
   assign is_digit = (rx_byte >= calts_pkg::CHAR_ZERO) && (rx_byte <= calts_pkg::CHAR_NINE);
   assign is_sign_char = ((rx_byte == calts_pkg::CHAR_MINUS) ||
                          (rx_byte == calts_pkg::CHAR_PLUS)) && (field_chars_ff == '0);
   assign digit     = rx_byte[3:0];
   assign frac_room = (frac_ff != 2'(calts_pkg::FRAC_MAX));

   // Signed value of the field being closed.
   assign commit_mag   = {1'b0, acc_ff};
   assign commit_value = sign_ff ? (calts_pkg::ANGLE_W'(0) - commit_mag) : commit_mag;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         parsed_next[i] = (field_num_ff == 2'(i)) ? commit_value : parsed_ff[i];
      end
   end

   // Accumulator step for one digit: shift in before the point, add a weight after it.
   assign times_ten  = ({5'b0, acc_ff} << 3) + ({5'b0, acc_ff} << 1);
   assign digit_thou = 14'(digit) * 14'(calts_pkg::DIGIT_WEIGHT);
   assign frac_add   = 11'(digit) * 11'(calts_pkg::frac_scale(frac_ff));
   assign digit_sum  = point_ff ? ({5'b0, acc_ff} + SUM_W'(frac_add))
                                : (times_ten + SUM_W'(digit_thou));
   assign digit_acc  = (digit_sum > {5'b0, calts_pkg::MAG_LIMIT}) ? calts_pkg::MAG_LIMIT
                                                                 : digit_sum[ACC_W-1:0];

   // Parser next state for one accepted beat.
   always_comb begin
      line_len_in    = line_len_ff;
      last_cr_in     = last_cr_ff;
      field_num_in   = field_num_ff;
      field_chars_in = field_chars_ff;
      sign_in        = sign_ff;
      point_in       = point_ff;
      stop_in        = stop_ff;
      frac_in        = frac_ff;
      acc_in         = acc_ff;
      for (int i = 0; i < 3; i++) begin
         parsed_in[i] = parsed_ff[i];
      end
      event_push = 1'b0;

      if (byte_accept) begin
         if (is_close || is_comma) begin
            for (int i = 0; i < 3; i++) begin
               parsed_in[i] = parsed_next[i];
            end
            if (field_num_ff != 2'd3) begin
               field_num_in = field_num_ff + 2'd1;
            end
            field_chars_in = '0;
            sign_in        = 1'b0;
            point_in       = 1'b0;
            stop_in        = 1'b0;
            frac_in        = '0;
            acc_in         = '0;
         end else if (field_chars_ff < CW'(FIELD_CHARS)) begin
            field_chars_in = field_chars_ff + CW'(1);
            if (!stop_ff) begin
               if (is_sign_char) begin
                  sign_in = (rx_byte == calts_pkg::CHAR_MINUS);
               end else if ((rx_byte == calts_pkg::CHAR_POINT) && !point_ff) begin
                  point_in = 1'b1;
               end else if (is_digit) begin
                  if (!point_ff || frac_room) begin
                     acc_in = digit_acc;
                  end
                  if (point_ff && frac_room) begin
                     frac_in = frac_ff + 2'd1;
                  end
               end else begin
                  stop_in = 1'b1;
               end
            end
         end

         if (is_close) begin
            line_len_in  = '0;
            last_cr_in   = 1'b0;
            field_num_in = '0;
            event_push   = stream_en_ff;
         end else begin
            last_cr_in = (rx_byte == calts_pkg::CHAR_CR);
            if (line_len_ff < LW'(MAX_LINE)) begin
               line_len_in = line_len_ff + LW'(1);
            end
         end
      end
   end

   assign event_data.yaw   = parsed_next[0];
   assign event_data.pitch = parsed_next[1];
   assign event_data.roll  = parsed_next[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_en_ff   <= 1'b0;
         line_len_ff    <= '0;
         last_cr_ff     <= 1'b0;
         field_num_ff   <= '0;
         field_chars_ff <= '0;
         sign_ff        <= 1'b0;
         point_ff       <= 1'b0;
         stop_ff        <= 1'b0;
         frac_ff        <= '0;
         acc_ff         <= '0;
         for (int i = 0; i < 3; i++) begin
            parsed_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            stream_en_ff <= csr_stream_enable;
         end
         line_len_ff    <= line_len_in;
         last_cr_ff     <= last_cr_in;
         field_num_ff   <= field_num_in;
         field_chars_ff <= field_chars_in;
         sign_ff        <= sign_in;
         point_ff       <= point_in;
         stop_ff        <= stop_in;
         frac_ff        <= frac_in;
         acc_ff         <= acc_in;
         for (int i = 0; i < 3; i++) begin
            parsed_ff[i] <= parsed_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/calts_back.sv =====
`default_nettype none

module calts_back #(
   parameter int OUT_DEPTH = calts_pkg::OUT_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            event_valid,
   input  wire calts_pkg::line_event_type       event_data,
   output logic                                 event_pop,
   input  wire logic [$clog2(OUT_DEPTH+1)-1:0]  out_count,
   output logic                                 result_push,
   output calts_pkg::result_type                result_data
);

   localparam int OCW     = $clog2(OUT_DEPTH + 1);
   localparam int OCC_W   = OCW + 2;
   localparam int DIFF_W  = calts_pkg::DIFF_W;
   localparam int MAG_W   = calts_pkg::MAG_W;
   localparam int SPEED_W = calts_pkg::SPEED_W;
   localparam int SCALE_W = calts_pkg::SCALE_W;
   localparam int STEPS   = calts_pkg::DIV_STEPS;

   calts_pkg::line_event_type base_ff;
   logic                      base_zero;
   logic [OCC_W-1:0]          occupancy;
   logic                      room;
   logic                      load_base;
   logic                      issue;

   logic                      s1_v_ff, s2_v_ff, s3_v_ff;
   logic signed [DIFF_W-1:0]  diff_in [2];
   logic signed [DIFF_W-1:0]  diff_ff [2];
   logic signed [DIFF_W-1:0]  abs_diff [2];
   logic                      sat_hi_in [2];
   logic                      sat_lo_in [2];
   logic                      sat_hi_ff [2];
   logic                      sat_lo_ff [2];
   logic                      neg_ff [2];
   logic [MAG_W-1:0]          mag_ff [2];
   logic [STEPS-1:0]          quot [2];
   logic [MAG_W-1:0]          rem [2];
   calts_pkg::speed_type      speed_in [2];
   calts_pkg::speed_type      speed_ff [2];
   logic signed [SCALE_W-1:0] scaled [2];
   logic signed [SCALE_W-1:0] dac_raw [2];
   calts_pkg::dac_type        dac [2];

   // Issue a line only when the result queue has room for everything in flight.
   assign base_zero = (base_ff == '0);
   assign occupancy = OCC_W'(out_count) + OCC_W'(s1_v_ff) + OCC_W'(s2_v_ff) + OCC_W'(s3_v_ff);
   assign room      = (occupancy < OCC_W'(OUT_DEPTH));
   assign load_base = event_valid && base_zero;
   assign issue     = event_valid && !base_zero && room;
   assign event_pop = load_base || issue;

   // Stage one: angle change against the baseline, lane 0 pitch and lane 1 roll.
   assign diff_in[0] = {event_data.pitch[calts_pkg::ANGLE_W-1], event_data.pitch} -
                       {base_ff.pitch[calts_pkg::ANGLE_W-1], base_ff.pitch};
   assign diff_in[1] = {event_data.roll[calts_pkg::ANGLE_W-1], event_data.roll} -
                       {base_ff.roll[calts_pkg::ANGLE_W-1], base_ff.roll};

   // Stage two: saturation checks and magnitude of the change.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         sat_hi_in[l] = (diff_ff[l] >= $signed(DIFF_W'(calts_pkg::SAT_HI)));
         sat_lo_in[l] = (diff_ff[l] <= -$signed(DIFF_W'(calts_pkg::SAT_LO)));
         abs_diff[l]  = diff_ff[l][DIFF_W-1] ? -diff_ff[l] : diff_ff[l];
      end
   end

   // Stage three: restoring division by nine degrees, one quotient bit per step.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rem[l]  = mag_ff[l];
         quot[l] = '0;
         for (int k = STEPS - 1; k >= 0; k--) begin
            if (rem[l] >= (MAG_W'(calts_pkg::SPEED_DIV) << k)) begin
               rem[l]     = rem[l] - (MAG_W'(calts_pkg::SPEED_DIV) << k);
               quot[l][k] = 1'b1;
            end
         end
         if (sat_hi_ff[l]) begin
            speed_in[l] = SPEED_W'(calts_pkg::SPEED_MAX);
         end else if (sat_lo_ff[l]) begin
            speed_in[l] = SPEED_W'(calts_pkg::SPEED_MIN);
         end else if (neg_ff[l]) begin
            speed_in[l] = SPEED_W'(0) - {1'b0, quot[l]};
         end else begin
            speed_in[l] = {1'b0, quot[l]};
         end
      end
   end

   // DAC codes from the registered speeds, clamped to the converter range.
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         scaled[l] = SCALE_W'(speed_ff[l]) * $signed(SCALE_W'(calts_pkg::DAC_STEP));
      end
      dac_raw[0] = scaled[0];
      dac_raw[1] = scaled[1] + $signed(SCALE_W'(calts_pkg::DAC_MID));
      for (int l = 0; l < 2; l++) begin
         if (dac_raw[l] < 0) begin
            dac[l] = '0;
         end else if (dac_raw[l] > $signed(SCALE_W'(calts_pkg::DAC_MAX))) begin
            dac[l] = calts_pkg::DAC_W'(calts_pkg::DAC_MAX);
         end else begin
            dac[l] = dac_raw[l][calts_pkg::DAC_W-1:0];
         end
      end
   end

   assign result_push                = s3_v_ff;
   assign result_data.run_speed      = speed_ff[0];
   assign result_data.right_speed    = speed_ff[1];
   assign result_data.run_dac_code   = dac[0];
   assign result_data.right_dac_code = dac[1];

   // Baselines and stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (load_base) begin
            base_ff <= event_data;
         end
         s1_v_ff <= issue;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         diff_ff[l]   <= diff_in[l];
         sat_hi_ff[l] <= sat_hi_in[l];
         sat_lo_ff[l] <= sat_lo_in[l];
         neg_ff[l]    <= diff_ff[l][DIFF_W-1];
         mag_ff[l]    <= abs_diff[l][MAG_W-1:0];
         speed_ff[l]  <= speed_in[l];
      end
   end

endmodule

`default_nettype wire

// ===== sv/csv_angle_line_to_speed.sv =====
`default_nettype none

// Channel  Ports                                   Beat
// -------  --------------------------------------  -------------------------------
// req      req_push, req_full, req_rx_byte         one received character
// rsp      rsp_pop, rsp_empty, rsp_run_speed, ...  speeds and DAC codes of one line
// csr      csr_write_enable, csr_stream_enable     stream enable bit
//
// One character is taken every cycle while req_full is low; each accepted character updates the field parser.
// A result reaches the rsp side after the LF that closes its line has passed a
// line-event queue, then three speed stages (difference, magnitude, division by nine degrees).
// req_full rises only when the line-event queue is full, which happens only while the rsp
// side holds off results. Lines that set the baselines give no result.
// Reset is synchronous and clears all parser state, angles and baselines.

module csv_angle_line_to_speed #(
   parameter int FIELD_CHARS = calts_pkg::FIELD_CHARS_DEFAULT,
   parameter int MAX_LINE    = calts_pkg::MAX_LINE_DEFAULT,
   parameter int MID_DEPTH   = calts_pkg::MID_DEPTH_DEFAULT,
   parameter int OUT_DEPTH   = calts_pkg::OUT_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic [7:0]                           req_rx_byte,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic signed [calts_pkg::SPEED_W-1:0]      rsp_run_speed,
   output logic signed [calts_pkg::SPEED_W-1:0]      rsp_right_speed,
   output logic [calts_pkg::DAC_W-1:0]               rsp_run_dac_code,
   output logic [calts_pkg::DAC_W-1:0]               rsp_right_dac_code,
   input  wire logic                                 csr_write_enable,
   input  wire logic                                 csr_stream_enable
);

   localparam int EV_W  = $bits(calts_pkg::line_event_type);
   localparam int RES_W = $bits(calts_pkg::result_type);

   logic                                byte_accept;
   logic                                ev_push;
   calts_pkg::line_event_type           ev_push_data;
   logic [EV_W-1:0]                     ev_pop_bits;
   calts_pkg::line_event_type           ev_pop_data;
   logic                                ev_empty;
   logic                                ev_pop;
   logic                                res_push;
   calts_pkg::result_type               res_push_data;
   logic [RES_W-1:0]                    res_pop_bits;
   calts_pkg::result_type               res_pop_data;
   logic [$clog2(OUT_DEPTH+1)-1:0]      out_count;

   assign byte_accept = req_push && !req_full;

   calts_front #(
      .FIELD_CHARS (FIELD_CHARS),
      .MAX_LINE    (MAX_LINE)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_stream_enable (csr_stream_enable),
      .byte_accept       (byte_accept),
      .rx_byte           (req_rx_byte),
      .event_push        (ev_push),
      .event_data        (ev_push_data)
   );

   // Closed lines wait here so parsing stalls on the speed stages only when this queue is full.
   calts_fifo #(
      .WIDTH (EV_W),
      .DEPTH (MID_DEPTH)
   ) u_line_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev_push_data),
      .pop       (ev_pop),
      .pop_data  (ev_pop_bits),
      .full      (req_full),
      .empty     (ev_empty),
      .count     ()
   );

   assign ev_pop_data = ev_pop_bits;

   calts_back #(
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .event_valid (!ev_empty),
      .event_data  (ev_pop_data),
      .event_pop   (ev_pop),
      .out_count   (out_count),
      .result_push (res_push),
      .result_data (res_push_data)
   );

   // Finished results wait here for the consumer.
   calts_fifo #(
      .WIDTH (RES_W),
      .DEPTH (OUT_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_push_data),
      .pop       (rsp_pop),
      .pop_data  (res_pop_bits),
      .full      (),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   assign res_pop_data       = res_pop_bits;
   assign rsp_run_speed      = res_pop_data.run_speed;
   assign rsp_right_speed    = res_pop_data.right_speed;
   assign rsp_run_dac_code   = res_pop_data.run_dac_code;
   assign rsp_right_dac_code = res_pop_data.right_dac_code;

endmodule

`default_nettype wire

// ===== sv/calts_checker.sv =====
`default_nettype none

module calts_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_full,
   input wire logic                                 rsp_empty,
   input wire logic                                 rsp_pop,
   input wire logic signed [calts_pkg::SPEED_W-1:0] rsp_run_speed,
   input wire logic signed [calts_pkg::SPEED_W-1:0] rsp_right_speed,
   input wire logic [calts_pkg::DAC_W-1:0]          rsp_run_dac_code,
   input wire logic [calts_pkg::DAC_W-1:0]          rsp_right_dac_code
);

   // After reset both queues come up empty.
   assert property (@(posedge clock) reset |=> (!req_full && rsp_empty))
      else $error("queues not empty after reset");

   // A waiting result that is not taken stays in place.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_run_speed) && $stable(rsp_right_speed) &&
          $stable(rsp_run_dac_code) && $stable(rsp_right_dac_code)))
      else $error("waiting result changed before it was taken");

   // Backward run speed drives the run DAC to zero, fast run speed to full scale.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_run_speed[calts_pkg::SPEED_W-1]) |-> (rsp_run_dac_code == '0))
      else $error("run DAC code not zero for negative speed");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_run_speed[calts_pkg::SPEED_W-1] && (rsp_run_speed > 7'sd20)) |->
         (rsp_run_dac_code == 12'd4095))
      else $error("run DAC code not at full scale for high speed");

   // Zero right speed sits at the middle of the DAC range.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_right_speed != 7'sd0) || (rsp_right_dac_code == 12'd2048)))
      else $error("right DAC code off center for zero speed");

endmodule

bind csv_angle_line_to_speed calts_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_full           (req_full),
   .rsp_empty          (rsp_empty),
   .rsp_pop            (rsp_pop),
   .rsp_run_speed      (rsp_run_speed),
   .rsp_right_speed    (rsp_right_speed),
   .rsp_run_dac_code   (rsp_run_dac_code),
   .rsp_right_dac_code (rsp_right_dac_code)
);

`default_nettype wire

// ===== test/tb_csv_angle_line_to_speed.sv =====
`default_nettype none

module tb_csv_angle_line_to_speed;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int IDLE_PCT     = 38;

   logic                  clock              = 1'b0;
   logic                  reset              = 1'b1;
   logic                  req_push           = 1'b0;
   logic                  req_full;
   logic [7:0]            req_rx_byte        = 8'h00;
   logic                  rsp_empty;
   logic                  rsp_pop            = 1'b0;
   calts_pkg::speed_type  rsp_run_speed;
   calts_pkg::speed_type  rsp_right_speed;
   calts_pkg::dac_type    rsp_run_dac_code;
   calts_pkg::dac_type    rsp_right_dac_code;
   logic                  csr_write_enable   = 1'b0;
   logic                  csr_stream_enable  = 1'b0;

   bit                     steady       = 1'b0;
   int unsigned            failures     = 0;
   int unsigned            cycle_count  = 0;
   int unsigned            bytes_sent   = 0;
   calts_pkg::result_type  speed_q[$];

   // Shadow copy of the parser, the angles and the baselines.
   bit                     stream_on;
   int unsigned            line_len;
   bit                     saw_cr;
   int unsigned            field_idx;
   int unsigned            field_len;
   bit                     neg;
   bit                     has_point;
   bit                     stopped;
   int unsigned            frac_count;
   logic [31:0]            magnitude;
   calts_pkg::angle_type   angle_now[3];
   calts_pkg::angle_type   angle_base[3];

   always #10 clock = ~clock;

   csv_angle_line_to_speed i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_rx_byte        (req_rx_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_run_speed      (rsp_run_speed),
      .rsp_right_speed    (rsp_right_speed),
      .rsp_run_dac_code   (rsp_run_dac_code),
      .rsp_right_dac_code (rsp_right_dac_code),
      .csr_write_enable   (csr_write_enable),
      .csr_stream_enable  (csr_stream_enable)
   );

   // Run limit: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic void clear_field_state();
      field_len  = 0;
      neg        = 1'b0;
      has_point  = 1'b0;
      stopped    = 1'b0;
      frac_count = 0;
      magnitude  = '0;
   endfunction

   function automatic void clear_prediction();
      stream_on = 1'b0;
      line_len  = 0;
      saw_cr    = 1'b0;
      field_idx = 0;
      clear_field_state();
      for (int i = 0; i < 3; i++) begin
         angle_now[i]  = '0;
         angle_base[i] = '0;
      end
   endfunction

   // Store the finished field as a signed angle; fields past the third are dropped.
   function automatic void close_field();
      calts_pkg::angle_type value;
      value = neg ? -calts_pkg::angle_type'(magnitude) : calts_pkg::angle_type'(magnitude);
      if (field_idx < 3) begin
         angle_now[field_idx] = value;
         field_idx++;
      end
      clear_field_state();
   endfunction

   // Accumulate one character of a field in thousandths, saturating the magnitude.
   function automatic void take_char(logic [7:0] c);
      longint unsigned sum;
      int unsigned     digit;
      int unsigned     weight;
      if (field_len >= calts_pkg::FIELD_CHARS_DEFAULT) return;
      field_len++;
      if (stopped) return;
      if ((c == calts_pkg::CHAR_MINUS || c == calts_pkg::CHAR_PLUS) && field_len == 1) begin
         if (c == calts_pkg::CHAR_MINUS) neg = 1'b1;
      end else if (c == calts_pkg::CHAR_POINT && !has_point) begin
         has_point = 1'b1;
      end else if (c >= calts_pkg::CHAR_ZERO && c <= calts_pkg::CHAR_NINE) begin
         digit = {24'd0, c - calts_pkg::CHAR_ZERO};
         sum   = {32'd0, magnitude};
         if (!has_point) begin
            sum = sum * 10 + digit * calts_pkg::DIGIT_WEIGHT;
         end else if (frac_count < calts_pkg::FRAC_MAX) begin
            weight = (frac_count == 0) ? 100 : (frac_count == 1) ? 10 : 1;
            sum = sum + digit * weight;
            frac_count++;
         end
         if (sum > 64'(calts_pkg::MAG_LIMIT)) sum = 64'(calts_pkg::MAG_LIMIT);
         magnitude = sum[31:0];
      end else begin
         stopped = 1'b1;
      end
   endfunction

   function automatic int speed_step(calts_pkg::angle_type now, calts_pkg::angle_type base);
      longint q;
      q = (longint'(now) - longint'(base)) / calts_pkg::SPEED_DIV;
      if (q > calts_pkg::SPEED_MAX) q = calts_pkg::SPEED_MAX;
      if (q < calts_pkg::SPEED_MIN) q = calts_pkg::SPEED_MIN;
      return int'(q);
   endfunction

   function automatic calts_pkg::dac_type dac_clamp(int v);
      if (v < 0) return '0;
      if (v > calts_pkg::DAC_MAX) return calts_pkg::dac_type'(calts_pkg::DAC_MAX);
      return v[calts_pkg::DAC_W-1:0];
   endfunction

   // Advance the shadow parser by one byte; returns one when a line gives speeds.
   function automatic bit predict_byte(logic [7:0] c, output calts_pkg::result_type r);
      int run_q;
      int right_q;
      r = '0;
      if (line_len > calts_pkg::CLOSE_MIN && saw_cr && c == calts_pkg::CHAR_LF) begin
         close_field();
         line_len  = 0;
         saw_cr    = 1'b0;
         field_idx = 0;
         if (!stream_on) return 1'b0;
         if (angle_base[0] == 0 && angle_base[1] == 0 && angle_base[2] == 0) begin
            for (int i = 0; i < 3; i++) angle_base[i] = angle_now[i];
            return 1'b0;
         end
         run_q   = speed_step(angle_now[1], angle_base[1]);
         right_q = speed_step(angle_now[2], angle_base[2]);
         r.run_speed      = calts_pkg::speed_type'(run_q);
         r.right_speed    = calts_pkg::speed_type'(right_q);
         r.run_dac_code   = dac_clamp(calts_pkg::DAC_STEP * run_q);
         r.right_dac_code = dac_clamp(calts_pkg::DAC_MID + calts_pkg::DAC_STEP * right_q);
         return 1'b1;
      end
      if (c == calts_pkg::CHAR_COMMA) close_field();
      else take_char(c);
      saw_cr = (c == calts_pkg::CHAR_CR);
      if (line_len < calts_pkg::MAX_LINE_DEFAULT) line_len++;
      return 1'b0;
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         failures++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // Result side: random pop stalls, and every popped beat is checked in order.
   always @(posedge clock) begin
      calts_pkg::result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= steady || ($urandom_range(99) >= IDLE_PCT);
         if (rsp_pop && !rsp_empty) begin
            if (speed_q.size() == 0) begin
               failures++;
               $error("unexpected result beat: run_speed %0d, right_speed %0d",
                      rsp_run_speed, rsp_right_speed);
            end else begin
               want = speed_q.pop_front();
               compare_field("run_speed", int'(want.run_speed), int'(rsp_run_speed));
               compare_field("right_speed", int'(want.right_speed), int'(rsp_right_speed));
               compare_field("run_dac_code", int'(want.run_dac_code),
                             int'(rsp_run_dac_code));
               compare_field("right_dac_code", int'(want.right_dac_code),
                             int'(rsp_right_dac_code));
            end
         end
      end
   end

   // Send one character beat, with a random gap in front unless the run is steady.
   task automatic send_byte(input logic [7:0] value);
      calts_pkg::result_type want;
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_push    <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_full);
      bytes_sent++;
      if (predict_byte(value, want)) speed_q.push_back(want);
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_byte(text[i]);
   endtask

   task automatic send_line(input string text);
      send_text(text);
      send_byte(calts_pkg::CHAR_CR);
      send_byte(calts_pkg::CHAR_LF);
   endtask

   // Idle the input, then wait until no result is due and the pipeline has drained.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (speed_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_stream_enable(input bit value);
      wait_idle();
      csr_write_enable  <= 1'b1;
      csr_stream_enable <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      stream_on = value;
   endtask

   // A decimal number with random sign, integer part, point and fraction.
   task automatic send_number();
      int unsigned pick;
      int unsigned int_digits;
      pick = $urandom_range(99);
      if (pick < 30) send_byte(calts_pkg::CHAR_MINUS);
      else if (pick < 40) send_byte(calts_pkg::CHAR_PLUS);
      int_digits = ($urandom_range(19) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      repeat (int_digits) send_byte(calts_pkg::CHAR_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(1)) begin
         send_byte(calts_pkg::CHAR_POINT);
         repeat ($urandom_range(0, 4)) send_byte(calts_pkg::CHAR_ZERO + 8'($urandom_range(9)));
      end
      if ($urandom_range(19) == 0) send_byte(8'($urandom_range(255)));
   endtask

   // Mostly well-formed lines, with noise lines and broken framing mixed in.
   task automatic send_random_line();
      int unsigned kind;
      int unsigned fields;
      kind = $urandom_range(99);
      if (kind < 75) begin
         fields = ($urandom_range(9) == 0) ? $urandom_range(1, 5) : 3;
         for (int i = 0; i < fields; i++) begin
            if (i != 0) send_byte(calts_pkg::CHAR_COMMA);
            send_number();
         end
         send_byte(calts_pkg::CHAR_CR);
         send_byte(calts_pkg::CHAR_LF);
      end else if (kind < 85) begin
         repeat ($urandom_range(1, 24)) send_byte(8'($urandom_range(255)));
         send_byte(calts_pkg::CHAR_CR);
         send_byte(calts_pkg::CHAR_LF);
      end else begin
         case ($urandom_range(2))
            0: begin
               // May be too short to close: then merges into the next line.
               send_number();
               send_byte(calts_pkg::CHAR_CR);
               send_byte(calts_pkg::CHAR_LF);
            end
            1: begin
               // LF without CR.
               send_number();
               send_byte(calts_pkg::CHAR_COMMA);
               send_number();
               send_byte(calts_pkg::CHAR_LF);
            end
            default: begin
               // CR followed by something other than LF.
               send_number();
               send_byte(calts_pkg::CHAR_CR);
               send_byte(calts_pkg::CHAR_CR);
               send_number();
            end
         endcase
      end
   endtask

   task automatic test_stream_disabled();
      // Reset leaves the stream off: a closed line gives nothing.
      send_line("10,20,30");
      write_stream_enable(1'b0);
      send_line("11,21,31");
   endtask

   task automatic test_baseline_capture();
      write_stream_enable(1'b1);
      // All-zero angles leave the baselines at zero, so the next line captures them.
      send_line("0,0,0");
      send_line("1.5,-2.25,+3.125");
   endtask

   task automatic test_speed_limits();
      send_line("0,999999999,-99999999");
      send_line("0,-999999999,999999999");
      send_line("0,1.5,3.125");
      send_line("0,10.5,-6");
      // Truncation toward zero just inside one step.
      send_line("0,-6.749,12.124");
   endtask

   task automatic test_field_syntax();
      send_line("1,6.75x9,3.1259");
      send_line("1,+-5,1.2.3");
      send_line("1,123456789012,.");
      send_line(",,");
   endtask

   task automatic test_line_framing();
      // Five bytes before the LF do not close; six do.
      send_line("1234");
      send_line("12,45");
      send_line("1,2,3,40,50");
      send_line("1,-20");
      send_text("5,6,7");
      send_byte(calts_pkg::CHAR_LF);
      send_line("8,9,10");
      // Line longer than the length counter.
      send_text("1,2,3,");
      repeat (32) begin
         send_byte(calts_pkg::CHAR_NINE);
         send_byte(calts_pkg::CHAR_COMMA);
      end
      send_byte(calts_pkg::CHAR_CR);
      send_byte(calts_pkg::CHAR_LF);
   endtask

   task automatic test_random_stream(input int unsigned count);
      int unsigned stop_at;
      stop_at = bytes_sent + count;
      while (bytes_sent < stop_at) send_random_line();
   endtask

   initial begin
      clear_prediction();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_stream_disabled();
      test_baseline_capture();
      test_speed_limits();
      test_field_syntax();
      test_line_framing();
      test_random_stream(350);

      // A stretch with no idling on either side.
      steady = 1'b1;
      test_random_stream(200);
      steady = 1'b0;

      write_stream_enable(1'b0);
      test_random_stream(80);
      write_stream_enable(1'b1);
      test_random_stream(170);

      wait_idle();
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/calts_pkg.sv
sv/calts_fifo.sv
sv/calts_front.sv
sv/calts_back.sv
sv/csv_angle_line_to_speed.sv
sv/calts_checker.sv
test/tb_csv_angle_line_to_speed.sv
